/* rtl/shb_pkg.sv */
// shared types and constants for the string hash bucket block
package shb_pkg;

    localparam int unsigned HASH_W   = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned HASH_SHIFT = 5;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = QPTR_W + 1;
    localparam int unsigned DIV_CNT_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] HASH_SEED  = HASH_W'(5381);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1000);

    // finished hash handed from the front to the queue
    typedef struct packed {
        logic              push;
        logic [HASH_W-1:0] hash;
    } push_word_t;

    // queue head as seen by the back part
    typedef struct packed {
        logic              avail;
        logic [HASH_W-1:0] hash;
    } head_word_t;

endpackage

/* rtl/shb_front.sv */
// front part: takes bytes, keeps the running hash, queues it at the terminator
module shb_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [shb_pkg::BYTE_W-1:0]          char_byte,
    input  logic                                q_full,
    output shb_pkg::push_word_t                 push_out
);

    logic [shb_pkg::HASH_W-1:0] hash_reg;
    logic [shb_pkg::HASH_W-1:0] hash_next;
    logic                       accept;
    logic                       term;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign term     = (char_byte == '0);

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (term)
            begin
                hash_next = shb_pkg::HASH_SEED;
            end
            else
            begin
                // hash * 33 + byte
                hash_next = (hash_reg << shb_pkg::HASH_SHIFT) + hash_reg
                          + {{(shb_pkg::HASH_W-shb_pkg::BYTE_W){1'b0}}, char_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= shb_pkg::HASH_SEED;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign push_out.push = accept && term;
    assign push_out.hash = hash_reg;

endmodule

/* rtl/shb_queue.sv */
// short queue of finished hashes between the front and back parts
module shb_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  shb_pkg::push_word_t        push_in,
    input  logic                       pop,
    output logic                       full,
    output shb_pkg::head_word_t        head
);

    logic [shb_pkg::HASH_W-1:0] slot_reg [shb_pkg::QDEPTH];
    logic [shb_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [shb_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [shb_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [shb_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [shb_pkg::QCNT_W-1:0] count_reg;
    logic [shb_pkg::QCNT_W-1:0] count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = (count_reg == shb_pkg::QCNT_W'(shb_pkg::QDEPTH));
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.avail = (count_reg != '0);
    assign head.hash  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + shb_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + shb_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + shb_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - shb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_in.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/shb_back.sv */
// back part: bit-serial 64 by 16 remainder and the output register
module shb_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  shb_pkg::head_word_t        head,
    input  logic [shb_pkg::SIZE_W-1:0] size,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [shb_pkg::SIZE_W-1:0] bucket_index
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } back_state_t;

    back_state_t                     state_reg;
    back_state_t                     state_next;
    logic [shb_pkg::HASH_W-1:0]      dividend_reg;
    logic [shb_pkg::HASH_W-1:0]      dividend_next;
    logic [shb_pkg::SIZE_W-1:0]      divisor_reg;
    logic [shb_pkg::SIZE_W-1:0]      divisor_next;
    logic [shb_pkg::SIZE_W-1:0]      rem_reg;
    logic [shb_pkg::SIZE_W-1:0]      rem_next;
    logic [shb_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [shb_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic [shb_pkg::SIZE_W:0]        rem_shift;
    logic [shb_pkg::SIZE_W:0]        rem_sub;

    // one quotient bit per cycle, remainder stays below the divisor
    assign rem_shift = {rem_reg, dividend_reg[shb_pkg::HASH_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    always_comb
    begin
        state_next    = state_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        pop           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.avail)
                begin
                    pop           = 1'b1;
                    dividend_next = head.hash;
                    divisor_next  = size;
                    cnt_next      = '0;
                    if (size == '0)
                    begin
                        // size zero means 65536 buckets
                        rem_next   = head.hash[shb_pkg::SIZE_W-1:0];
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rem_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, divisor_reg})
                begin
                    rem_next = rem_sub[shb_pkg::SIZE_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[shb_pkg::SIZE_W-1:0];
                end
                dividend_next = {dividend_reg[shb_pkg::HASH_W-2:0], 1'b0};
                cnt_next      = cnt_reg + shb_pkg::DIV_CNT_W'(1);
                if (cnt_reg == shb_pkg::DIV_CNT_W'(shb_pkg::HASH_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign out_valid    = (state_reg == ST_OUT);
    assign bucket_index = rem_reg;

endmodule

/* rtl/string_hash_bucket_unit.sv */
// top level of the string hash bucket block
// djb2 string hash reduced to a bucket index.
// input channel: one string byte per word on char_byte with in_valid and
//   in_stall; a zero byte ends the string. nonzero bytes are taken one per
//   cycle while the queue has room and fold into a 64-bit running hash.
// output channel: bucket_index with out_valid and out_stall, one word per
//   terminator, equal to the hash modulo bucket_count (size 0 counts as 65536).
// config channel: cfg_valid / cfg_ready with bucket_count as data; always
//   ready, write only while the block is idle. resets to 1000 buckets.
// a taken terminator pushes its hash into the queue; the back part pops one
//   hash while idle, runs the bit-serial remainder (skipped when the size is
//   zero), then holds the result on the output until it is taken, and only
//   then takes the next hash. bytes keep flowing.
// a 4-deep queue of finished hashes sits between hash and remainder; the
//   input stalls only while that queue is full.
// a stalled output holds its word; reset clears the hash to 5381 and
//   empties the queue and the output.
module string_hash_bucket_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [shb_pkg::BYTE_W-1:0]         char_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [shb_pkg::SIZE_W-1:0]         bucket_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [shb_pkg::SIZE_W-1:0]         bucket_count
);

    logic [shb_pkg::SIZE_W-1:0] size_reg;
    shb_pkg::push_word_t        push_word;
    shb_pkg::head_word_t        head_word;
    logic                       q_full;
    logic                       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= shb_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= bucket_count;
        end
    end

    shb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .char_byte(char_byte),
        .q_full   (q_full),
        .push_out (push_word)
    );

    shb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_in(push_word),
        .pop    (pop),
        .full   (q_full),
        .head   (head_word)
    );

    shb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_word),
        .size        (size_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bucket_index(bucket_index)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_word.push |-> !q_full)
        else $error("hash pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_word.avail)
        else $error("pop from an empty queue");

    a_out_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !out_valid || (size_reg == '0))
        else $error("result shown before the remainder finished");
`endif

endmodule

/* tb/sv/shb_bucket_checker.sv */
`timescale 1ns / 100ps
// checker for the string hash bucket block: folds the byte stream and compares bucket indexes
module shb_bucket_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [shb_pkg::BYTE_W-1:0] char_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [shb_pkg::SIZE_W-1:0] bucket_index,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [shb_pkg::SIZE_W-1:0] bucket_count,
    output int                         mismatches,
    output int                         outstanding,
    output int                         buckets_checked
);

    logic [shb_pkg::HASH_W-1:0] hash_model;
    logic [shb_pkg::SIZE_W-1:0] size_model;
    logic [shb_pkg::SIZE_W-1:0] bucket_expect_q[$];

    function automatic logic [shb_pkg::HASH_W-1:0] djb2_fold(
        input logic [shb_pkg::HASH_W-1:0] h,
        input logic [shb_pkg::BYTE_W-1:0] b);
        return (h << shb_pkg::HASH_SHIFT) + h + shb_pkg::HASH_W'(b);
    endfunction

    // a size of zero stands for 65536 buckets
    function automatic logic [shb_pkg::SIZE_W-1:0] bucket_of_hash(
        input logic [shb_pkg::HASH_W-1:0] h,
        input logic [shb_pkg::SIZE_W-1:0] size);
        if (size == '0)
            return h[shb_pkg::SIZE_W-1:0];
        return shb_pkg::SIZE_W'(h % shb_pkg::HASH_W'(size));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        buckets_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [shb_pkg::SIZE_W-1:0] want;
        if (!rst_n)
        begin
            hash_model = shb_pkg::HASH_SEED;
            size_model = shb_pkg::SIZE_RESET;
            bucket_expect_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (bucket_expect_q.size() == 0)
                    report_mismatch($sformatf("bucket_index %0d with nothing expected",
                                              bucket_index));
                else
                begin
                    want = bucket_expect_q.pop_front();
                    if (bucket_index !== want)
                        report_mismatch($sformatf("bucket_index %0d, expected %0d",
                                                  bucket_index, want));
                    buckets_checked <= buckets_checked + 1;
                end
            end
            if (cfg_valid && cfg_ready)
                size_model = bucket_count;
            if (in_valid && !in_stall)
            begin
                if (char_byte != '0)
                    hash_model = djb2_fold(hash_model, char_byte);
                else
                begin
                    // terminator word: one bucket, hash back to its seed
                    bucket_expect_q.push_back(bucket_of_hash(hash_model, size_model));
                    hash_model = shb_pkg::HASH_SEED;
                end
            end
            outstanding <= bucket_expect_q.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// top of the string hash bucket testbench: clock, reset, byte stimulus and verdict
module testbench;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_BYTES   = 75;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic [shb_pkg::BYTE_W-1:0] char_byte    = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic [shb_pkg::SIZE_W-1:0] bucket_index;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [shb_pkg::SIZE_W-1:0] bucket_count = '0;

    int mismatches;
    int outstanding;
    int buckets_checked;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    int sizes_written = 0;
    int quiet_cycles  = 0;
    bit hold_request  = 1'b0;
    bit hold_active   = 1'b0;

    always #2 clk = ~clk;

    string_hash_bucket_unit u_dut (.*);

    shb_bucket_checker u_check (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [shb_pkg::BYTE_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'hFF;
        if (r == 1)
            return 8'h01;
        return shb_pkg::BYTE_W'($urandom_range(1, 255));
    endfunction

    // mostly short strings, some long enough to wrap the 64-bit hash
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r < 7)
            return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    task automatic send_byte(input logic [shb_pkg::BYTE_W-1:0] b, input int gap);
        in_valid <= 1'b1;
        char_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        if (b == '0)
            strings_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // settle leaves the input idle after the terminator word
    task automatic send_string(input int len, input bit settle);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
            send_byte(pick_char(), steady ? 0 : pick_gap());
        send_byte('0, settle ? 1 : (steady ? 0 : pick_gap()));
    endtask

    task automatic run_phase(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_string(pick_length(), 1'b0);
        send_string(0, 1'b1);
    endtask

    task automatic write_size(input logic [shb_pkg::SIZE_W-1:0] v);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        bucket_count <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sizes_written++;
    endtask

    // output side: random stall patterns, plus one long hold on request
    initial
    begin
        int mode;
        int span;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                hold_active = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4)
                span = $urandom_range(1, 40);
            else if (mode < 8)
                span = $urandom_range(1, 20);
            else if (mode == 8)
                span = $urandom_range(1, 4);
            else
                span = $urandom_range(20, 60);
            repeat (span)
            begin
                if (mode < 4)
                    out_stall <= 1'b0;
                else if (mode < 8)
                    out_stall <= 1'($urandom_range(0, 1));
                else
                    out_stall <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer", QUIET_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset size of 1000 buckets
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 2);
        send_byte(8'h01, 0);
        send_byte(8'h00, 0);
        send_byte(8'h80, 1);
        send_byte(8'h7F, 0);
        send_byte(8'h00, 0);
        // long run of 0xff wraps the hash several times over
        for (int k = 0; k < 14; k++)
            send_byte(8'hFF, pick_gap());
        send_byte(8'h00, 1);

        write_size(shb_pkg::SIZE_W'(1));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'(65535));
        run_phase(PHASE_BYTES);

        // hold the output while short strings keep coming, so the queue fills
        hold_request = 1'b1;
        wait (hold_active);
        for (int k = 0; k < 40; k++)
            send_byte((k % 3 == 0) ? 8'h00 : pick_char(), 0);
        send_byte(8'h00, 1);

        write_size(shb_pkg::SIZE_W'(0));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'(7));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'(32768));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'($urandom_range(2, 65534)));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'($urandom_range(2, 300)));
        run_phase(PHASE_BYTES);
        write_size(shb_pkg::SIZE_W'(1000));
        run_phase(PHASE_BYTES);

        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d bytes in %0d strings, %0d bucket indexes compared",
                 bytes_sent, strings_sent, buckets_checked);
        $display("table sizes: reset value and %0d writes incl. 1, 65535 and 0; long hold",
                 sizes_written);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
